>>> rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int AW           = 12;   // header offset
    localparam int LW           = 13;   // length and link

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ISFREE   = 3'd4;

    typedef struct packed {
        logic [LW-1:0] len;
        logic          free;
        logic [LW-1:0] link;
    } t_hdr;

    typedef struct packed {
        logic          re;
        logic [AW-1:0] raddr;
        logic          we;
        logic [AW-1:0] waddr;
        t_hdr          wdata;
    } t_mem_req;

endpackage
`default_nettype wire

>>> rtl/ffha_mem.sv
`default_nettype none
module ffha_mem (
    input  wire                    i_clk,
    input  wire ffha_pkg::t_mem_req i_req,
    output ffha_pkg::t_hdr         o_q
);
    import ffha_pkg::*;

    t_hdr mem [ARENA_BYTES];
    t_hdr r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

>>> rtl/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_kind,
    input  wire [12:0]          i_req_size,
    input  wire [11:0]          i_req_addr,
    output ffha_pkg::t_mem_req  o_req,
    input  wire ffha_pkg::t_hdr i_q,
    output logic                o_res_valid,
    input  wire                 i_res_room,
    output logic [11:0]         o_res_addr,
    output logic [2:0]          o_res_status
);
    import ffha_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_FNEXT  = 4'd5;
    localparam logic [3:0] S_FWCUR  = 4'd6;
    localparam logic [3:0] S_FWPREV = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [LW-1:0] END_LINK = LW'(ARENA_BYTES);
    localparam logic [LW-1:0] HDR_L    = LW'(HEADER_BYTES);
    localparam logic [AW-1:0] HDR_A    = AW'(HEADER_BYTES);

    logic [3:0]    r_state, n_state;
    logic          r_ready, n_ready;
    logic          r_kind;
    logic [LW-1:0] r_size;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_cur, n_cur;
    t_hdr          r_cur_hdr, n_cur_hdr;
    logic [AW-1:0] r_prev, n_prev;
    t_hdr          r_prev_hdr, n_prev_hdr;
    logic          r_prev_ok, n_prev_ok;
    logic [2:0]    r_status, n_status;
    logic [AW-1:0] r_paddr, n_paddr;

    logic          accept;
    logic [LW-1:0] left;
    logic [13:0]   tail;
    logic [AW-1:0] target;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign left   = i_q.len - r_size;
    assign tail   = {2'b00, r_cur} + 14'(HEADER_BYTES) + {1'b0, r_size};
    assign target = r_addr - HDR_A;

    always_comb begin
        n_state    = r_state;
        n_ready    = r_ready;
        n_cur      = r_cur;
        n_cur_hdr  = r_cur_hdr;
        n_prev     = r_prev;
        n_prev_hdr = r_prev_hdr;
        n_prev_ok  = r_prev_ok;
        n_status   = r_status;
        n_paddr    = r_paddr;
        o_req      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = r_ready ? S_START : S_INIT;
                end
            end
            S_INIT: begin
                // whole arena becomes one free block
                o_req.we         = 1'b1;
                o_req.waddr      = '0;
                o_req.wdata.len  = END_LINK - HDR_L;
                o_req.wdata.free = 1'b1;
                o_req.wdata.link = END_LINK;
                n_ready          = 1'b1;
                n_state          = S_START;
            end
            S_START: begin
                n_paddr   = '0;
                n_cur     = '0;
                n_prev_ok = 1'b0;
                if (!r_kind && r_size == '0) begin
                    n_status = ST_ZERO;
                    n_state  = S_DONE;
                end else if (r_kind && r_addr < HDR_A) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.raddr = '0;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (!r_kind) begin
                    if (i_q.free && i_q.len >= r_size) begin
                        n_status = ST_OK;
                        n_paddr  = r_cur + HDR_A;
                        o_req.we = 1'b1;
                        if (left > HDR_L && tail[13:12] == 2'b00) begin
                            // write the free tail first, then the shrunk head
                            o_req.waddr      = tail[AW-1:0];
                            o_req.wdata.len  = left - HDR_L;
                            o_req.wdata.free = 1'b1;
                            o_req.wdata.link = i_q.link;
                            n_cur_hdr.len    = r_size;
                            n_cur_hdr.free   = 1'b0;
                            n_cur_hdr.link   = tail[LW-1:0];
                            n_state          = S_SPLIT;
                        end else begin
                            o_req.waddr      = r_cur;
                            o_req.wdata      = i_q;
                            o_req.wdata.free = 1'b0;
                            n_state          = S_DONE;
                        end
                    end else if (i_q.link >= END_LINK) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_cur       = i_q.link[AW-1:0];
                        o_req.re    = 1'b1;
                        o_req.raddr = i_q.link[AW-1:0];
                    end
                end else if (r_cur == target) begin
                    if (i_q.free) begin
                        n_status = ST_ISFREE;
                        n_state  = S_DONE;
                    end else begin
                        n_cur_hdr      = i_q;
                        n_cur_hdr.free = 1'b1;
                        if (i_q.link < END_LINK) begin
                            o_req.re    = 1'b1;
                            o_req.raddr = i_q.link[AW-1:0];
                            n_state     = S_FNEXT;
                        end else begin
                            n_state = S_FWCUR;
                        end
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_hdr = i_q;
                    n_prev_ok  = 1'b1;
                    if (i_q.link >= END_LINK) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_cur       = i_q.link[AW-1:0];
                        o_req.re    = 1'b1;
                        o_req.raddr = i_q.link[AW-1:0];
                    end
                end
            end
            S_SPLIT: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_cur;
                o_req.wdata = r_cur_hdr;
                n_state     = S_DONE;
            end
            S_FNEXT: begin
                // absorb a free next block
                if (i_q.free) begin
                    n_cur_hdr.len  = r_cur_hdr.len + i_q.len + HDR_L;
                    n_cur_hdr.link = i_q.link;
                end
                n_state = S_FWCUR;
            end
            S_FWCUR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_cur;
                o_req.wdata = r_cur_hdr;
                n_status    = ST_OK;
                n_state     = (r_prev_ok && r_prev_hdr.free) ? S_FWPREV : S_DONE;
            end
            S_FWPREV: begin
                o_req.we         = 1'b1;
                o_req.waddr      = r_prev;
                o_req.wdata.len  = r_prev_hdr.len + r_cur_hdr.len + HDR_L;
                o_req.wdata.free = 1'b1;
                o_req.wdata.link = r_cur_hdr.link;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_res_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
        if (accept) begin
            r_kind <= i_kind;
            r_size <= i_req_size;
            r_addr <= i_req_addr;
        end
        r_cur      <= n_cur;
        r_cur_hdr  <= n_cur_hdr;
        r_prev     <= n_prev;
        r_prev_hdr <= n_prev_hdr;
        r_prev_ok  <= n_prev_ok;
        r_status   <= n_status;
        r_paddr    <= n_paddr;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_addr   = r_paddr;
    assign o_res_status = r_status;

endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator_top.sv
// Channel  Direction  Handshake             Payload
// in       sink       i_in_valid/o_in_stall  i_kind, i_req_size, i_req_addr
// out      source     o_out_valid/i_out_stall o_payload_addr, o_status
//
// One request at a time: accept, set-up, a walk of the block list that reads
// each header visited, then write-back and result hand-off, each header read
// going through the registered output of the header memory.
// The first request after reset also passes through an init state that lays down the arena.
// Reset clears control state only; header memory keeps no reset.
// A stalled result sits in the output register while the next request runs.
`default_nettype none
module first_fit_heap_allocator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_kind,
    input  wire  [12:0] i_req_size,
    input  wire  [11:0] i_req_addr,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [11:0] o_payload_addr,
    output logic [2:0]  o_status
);
    import ffha_pkg::*;

    t_mem_req   req;
    t_hdr       q;
    logic       res_valid;
    logic       room;
    logic [11:0] res_addr;
    logic [2:0]  res_status;
    logic       r_out_valid;
    logic [11:0] r_payload_addr;
    logic [2:0]  r_status;

    ffha_mem u_mem (
        .i_clk (i_clk),
        .i_req (req),
        .o_q   (q)
    );

    ffha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_req_size   (i_req_size),
        .i_req_addr   (i_req_addr),
        .o_req        (req),
        .i_q          (q),
        .o_res_valid  (res_valid),
        .i_res_room   (room),
        .o_res_addr   (res_addr),
        .o_res_status (res_status)
    );

    assign room = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (res_valid && room) || (r_out_valid && i_out_stall);
        end
        // hold the beat while stalled
        if (res_valid && room) begin
            r_payload_addr <= res_addr;
            r_status       <= res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_addr = r_payload_addr;
    assign o_status       = r_status;

endmodule
`default_nettype wire

>>> rtl/ffha_chk.sv
`default_nettype none
module ffha_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [11:0] o_payload_addr,
    input wire [2:0]  o_status
);
    import ffha_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("result beat dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_ISFREE)
        else $error("status code out of range");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_payload_addr == '0)
        else $error("address given with a failing status");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    a_addr_above_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK && o_payload_addr != '0
        |-> o_payload_addr >= 12'(HEADER_BYTES))
        else $error("payload address inside the first header");

endmodule

bind first_fit_heap_allocator_top ffha_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_payload_addr (o_payload_addr),
    .o_status       (o_status)
);
`default_nettype wire
